/* hdl/sopt_pkg.sv */
`default_nettype none

package sopt_pkg;

   // defaults for the top-level parameters
   localparam int SLOTS_DEFAULT      = 16;
   localparam int COORD_BITS_DEFAULT = 20;

   // fixed field widths
   localparam int SLOT_BITS   = 4;
   localparam int STATUS_BITS = 2;
   localparam int COUNT_BITS  = 5;

   // request kind carried on req_tuser
   localparam logic MODE_PLACE  = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE       = 2'd0,
      STATUS_NEG_RADIUS = 2'd1,
      STATUS_OVERLAP    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_WRITE,
      ST_DONE
   } state_type;

   // report from the serial distance unit to the sequencer
   typedef struct packed {
      logic done;
      logic overlap;
   } mac_status_type;

endpackage

`default_nettype wire

/* hdl/sopt_store.sv */
`default_nettype none

module sopt_store #(
   parameter int SLOTS     = sopt_pkg::SLOTS_DEFAULT,
   parameter int WORD_BITS = 4 * sopt_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
   input  wire logic [WORD_BITS-1:0]                   wr_data,
   input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
   output logic      [WORD_BITS-1:0]                   rd_data
);

   logic [WORD_BITS-1:0] mem [SLOTS];
   logic [WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hdl/sopt_mac.sv */
`default_nettype none

// Bit-serial sum of squares: dx^2 + dy^2 + dz^2 - reach^2, one multiplier
// bit per cycle, four terms in turn through one accumulator.
module sopt_mac #(
   parameter int COORD_BITS = sopt_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic [COORD_BITS-1:0] dx,
   input  wire logic [COORD_BITS-1:0] dy,
   input  wire logic [COORD_BITS-1:0] dz,
   input  wire logic [COORD_BITS-1:0] reach,
   output sopt_pkg::mac_status_type   status
);

   localparam int C  = COORD_BITS;
   localparam int AW = 2 * C + 3;
   localparam int BW = $clog2(C);

   logic                busy_ff,   busy_in;
   logic                done_ff,   done_in;
   logic [1:0]          term_ff,   term_in;
   logic [BW-1:0]       bit_ff,    bit_in;
   logic signed [AW-1:0] acc_ff,   acc_in;
   logic [2*C-1:0]      mcand_ff,  mcand_in;
   logic [C-1:0]        mplier_ff, mplier_in;
   logic [C-1:0]        ops_ff [3];
   logic [C-1:0]        ops_in [3];
   logic signed [AW-1:0] addend;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      term_in   = term_ff;
      bit_in    = bit_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      ops_in    = ops_ff;
      addend    = mplier_ff[0] ? AW'({1'b0, mcand_ff}) : '0;

      if (start) begin
         busy_in   = 1'b1;
         term_in   = 2'd0;
         bit_in    = '0;
         acc_in    = '0;
         mcand_in  = (2*C)'(dx);
         mplier_in = dx;
         ops_in[0] = dy;
         ops_in[1] = dz;
         ops_in[2] = reach;
      end else if (busy_ff) begin
         // last term is the reach, taken off the distance
         acc_in    = (term_ff == 2'd3) ? (acc_ff - addend) : (acc_ff + addend);
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         bit_in    = bit_ff + BW'(1);
         if (bit_ff == BW'(C - 1)) begin
            bit_in = '0;
            if (term_ff == 2'd3) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               term_in   = term_ff + 2'd1;
               mcand_in  = (2*C)'(ops_ff[0]);
               mplier_in = ops_ff[0];
               ops_in[0] = ops_ff[1];
               ops_in[1] = ops_ff[2];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      term_ff   <= term_in;
      bit_ff    <= bit_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      ops_ff    <= ops_in;
   end

   // touching counts as overlap
   assign status.done    = done_ff;
   assign status.overlap = acc_ff[AW-1] || (acc_ff == '0);

endmodule

`default_nettype wire

/* hdl/sphere_overlap_placement_table.sv */
`default_nettype none

// Sphere placement table. Holds SLOTS spheres (centre, radius, valid) and
// takes one request transaction at a time on req_: place/move (tuser 0) or
// remove (tuser 1). A place with a negative radius is refused (status 1); a
// place whose sphere overlaps or touches any other valid sphere is refused
// (status 2) and leaves the table unchanged; otherwise status 0. Every
// request returns exactly one rsp_ transaction with the status and the
// number of valid slots afterwards. A slot number beyond the table changes
// nothing and returns status 0.
// After reset the table runs a clearing pass over every slot before
// req_tready rises. A remove goes through one memory read to learn whether
// the slot was occupied, then the write. A place refused for a negative
// radius, or a request for a slot beyond the table, goes straight to the
// response. A place sweeps the whole table through the single read port of
// the sphere memory, one slot after another, and each valid slot other than
// its own goes through the bit-serial distance unit (one multiplier bit per
// cycle over dx, dy, dz and the radius sum); the sweep stops early at the
// first overlap. The next request is taken while a finished response still
// waits on rsp_; a second finished response waits inside until the first is
// taken, and req_tready stays low meanwhile.
module sphere_overlap_placement_table #(
   parameter int SLOTS      = sopt_pkg::SLOTS_DEFAULT,
   parameter int COORD_BITS = sopt_pkg::COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,

   input  wire logic req_tvalid,
   output logic      req_tready,
   // slot[3:0], pos_x, pos_y, pos_z, radius (COORD_BITS each), zero pad
   input  wire logic [((sopt_pkg::SLOT_BITS + 4*COORD_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // mode: 0 place or move, 1 remove
   input  wire logic req_tuser,

   output logic       rsp_tvalid,
   input  wire logic  rsp_tready,
   // status[1:0], occupied_count[6:2], zero pad
   output logic [7:0] rsp_tdata
);

   localparam int C  = COORD_BITS;
   localparam int SB = sopt_pkg::SLOT_BITS;
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam int WB = 4 * C;   // valid, x, y, z, radius (C-1)

   // request fields
   logic [SB-1:0] req_slot;
   logic [C-1:0]  req_x, req_y, req_z, req_r;

   assign req_slot = req_tdata[SB-1:0];
   assign req_x    = req_tdata[SB+C-1:SB];
   assign req_y    = req_tdata[SB+2*C-1:SB+C];
   assign req_z    = req_tdata[SB+3*C-1:SB+2*C];
   assign req_r    = req_tdata[SB+4*C-1:SB+3*C];

   // control
   sopt_pkg::state_type  state_ff, state_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        count_ff, count_in;
   logic                 self_valid_ff, self_valid_in;
   sopt_pkg::status_type status_ff, status_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // request payload, centres in offset binary
   logic          mode_ff, mode_in;
   logic [SB-1:0] slot_ff, slot_in;
   logic [C-1:0]  x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [C-2:0]  rad_ff, rad_in;

   sopt_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [sopt_pkg::COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;

   // memory and distance unit hookup
   logic          wr_en;
   logic [IW-1:0] wr_addr;
   logic [WB-1:0] wr_data;
   logic [WB-1:0] rd_data;
   logic          mac_start;
   logic [C-1:0]  dx, dy, dz, reach;
   sopt_pkg::mac_status_type mac_status;

   logic          rd_valid;
   logic [C-1:0]  rd_x, rd_y, rd_z;
   logic [C-2:0]  rd_r;
   logic [IW-1:0] slot_idx;
   logic          is_last;
   logic          rsp_free;

   function automatic logic [C-1:0] abs_diff(input logic [C-1:0] a, input logic [C-1:0] b);
      logic [C:0] d;
      d = {1'b0, a} - {1'b0, b};
      if (d[C]) begin
         d = -d;
      end
      return d[C-1:0];
   endfunction

   assign rd_valid = rd_data[0];
   assign rd_x     = rd_data[C:1];
   assign rd_y     = rd_data[2*C:C+1];
   assign rd_z     = rd_data[3*C:2*C+1];
   assign rd_r     = rd_data[4*C-1:3*C+1];

   assign dx    = abs_diff(rd_x, x_ff);
   assign dy    = abs_diff(rd_y, y_ff);
   assign dz    = abs_diff(rd_z, z_ff);
   assign reach = {1'b0, rd_r} + {1'b0, rad_ff};

   assign slot_idx = IW'(slot_ff);
   assign is_last  = (idx_ff == IW'(SLOTS - 1));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      self_valid_in = self_valid_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      mode_in       = mode_ff;
      slot_in       = slot_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      z_in          = z_ff;
      rad_in        = rad_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      req_tready    = 1'b0;
      mac_start     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = slot_idx;
      wr_data       = {rad_ff, z_ff, y_ff, x_ff, (mode_ff == sopt_pkg::MODE_PLACE)};

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         sopt_pkg::ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '0;
            idx_in  = idx_ff + IW'(1);
            if (is_last) begin
               idx_in   = '0;
               state_in = sopt_pkg::ST_IDLE;
            end
         end

         sopt_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mode_in       = req_tuser;
               slot_in       = req_slot;
               x_in          = {~req_x[C-1], req_x[C-2:0]};
               y_in          = {~req_y[C-1], req_y[C-2:0]};
               z_in          = {~req_z[C-1], req_z[C-2:0]};
               rad_in        = req_r[C-2:0];
               self_valid_in = 1'b0;
               status_in     = sopt_pkg::STATUS_DONE;
               if (32'(req_slot) >= 32'(SLOTS)) begin
                  state_in = sopt_pkg::ST_DONE;
               end else if (req_tuser == sopt_pkg::MODE_REMOVE) begin
                  // one read to learn whether the slot was occupied
                  idx_in   = IW'(req_slot);
                  state_in = sopt_pkg::ST_FETCH;
               end else if (req_r[C-1]) begin
                  status_in = sopt_pkg::STATUS_NEG_RADIUS;
                  state_in  = sopt_pkg::ST_DONE;
               end else begin
                  idx_in   = '0;
                  state_in = sopt_pkg::ST_FETCH;
               end
            end
         end

         sopt_pkg::ST_FETCH: begin
            state_in = sopt_pkg::ST_LOAD;
         end

         sopt_pkg::ST_LOAD: begin
            if (mode_ff == sopt_pkg::MODE_REMOVE) begin
               self_valid_in = rd_valid;
               state_in      = sopt_pkg::ST_WRITE;
            end else if (idx_ff == slot_idx) begin
               // own slot: skipped, but note whether this is a move
               self_valid_in = rd_valid;
               idx_in        = idx_ff + IW'(1);
               state_in      = is_last ? sopt_pkg::ST_WRITE : sopt_pkg::ST_FETCH;
            end else if (rd_valid) begin
               mac_start = 1'b1;
               state_in  = sopt_pkg::ST_MUL;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = is_last ? sopt_pkg::ST_WRITE : sopt_pkg::ST_FETCH;
            end
         end

         sopt_pkg::ST_MUL: begin
            if (mac_status.done) begin
               if (mac_status.overlap) begin
                  status_in = sopt_pkg::STATUS_OVERLAP;
                  state_in  = sopt_pkg::ST_DONE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = is_last ? sopt_pkg::ST_WRITE : sopt_pkg::ST_FETCH;
               end
            end
         end

         sopt_pkg::ST_WRITE: begin
            wr_en = 1'b1;
            if (mode_ff == sopt_pkg::MODE_REMOVE) begin
               if (self_valid_ff) begin
                  count_in = count_ff - CW'(1);
               end
            end else if (!self_valid_ff) begin
               count_in = count_ff + CW'(1);
            end
            state_in = sopt_pkg::ST_DONE;
         end

         sopt_pkg::ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = sopt_pkg::COUNT_BITS'(count_ff);
               state_in      = sopt_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = sopt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sopt_pkg::ST_CLEAR;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      self_valid_ff <= self_valid_in;
      status_ff     <= status_in;
      mode_ff       <= mode_in;
      slot_ff       <= slot_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      z_ff          <= z_in;
      rad_ff        <= rad_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   sopt_store #(
      .SLOTS     (SLOTS),
      .WORD_BITS (WB)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   sopt_mac #(
      .COORD_BITS (COORD_BITS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .dx     (dx),
      .dy     (dy),
      .dz     (dz),
      .reach  (reach),
      .status (mac_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_status_ff};

endmodule

`default_nettype wire

/* dv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS      = sopt_pkg::SLOTS_DEFAULT;
   localparam int COORD_BITS = sopt_pkg::COORD_BITS_DEFAULT;
   localparam int SLOT_BITS  = sopt_pkg::SLOT_BITS;
   localparam int COUNT_BITS = sopt_pkg::COUNT_BITS;
   localparam int REQ_W      = ((SLOT_BITS + 4*COORD_BITS + 7) / 8) * 8;

   // Worst place: full sweep plus 15 serial distance checks.
   localparam int TAIL_CYCLES   = 1500;
   localparam int CYCLE_LIMIT   = 12_000_000;
   localparam int PHASE_ITEMS   = 425;
   localparam int HOLDOFF_LEN   = 3000;
   localparam int NUM_DIRECTED  = 20;

   localparam int COORD_MAX = (1 << (COORD_BITS - 1)) - 1;
   localparam int COORD_MIN = -(1 << (COORD_BITS - 1));

   // One request row. 'given' marks rows whose answer is written out below;
   // all others are checked against the table predictor.
   typedef struct packed {
      logic                         mode;
      logic [SLOT_BITS-1:0]         slot;
      logic signed [COORD_BITS-1:0] pos_x;
      logic signed [COORD_BITS-1:0] pos_y;
      logic signed [COORD_BITS-1:0] pos_z;
      logic signed [COORD_BITS-1:0] radius;
      logic                         given;
      sopt_pkg::status_type         st;
      logic [COUNT_BITS-1:0]        cnt;
   } sphere_row_type;

   typedef struct {
      sopt_pkg::status_type  status;
      logic [COUNT_BITS-1:0] count;
   } verdict_type;

   logic clock;
   logic reset = 1'b1;

   logic             req_tvalid = 1'b0;
   logic             req_tready;
   // slot[3:0], pos_x, pos_y, pos_z, radius (COORD_BITS each), zero pad
   logic [REQ_W-1:0] req_tdata  = '0;
   // mode: 0 place or move, 1 remove
   logic             req_tuser  = 1'b0;

   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   // status[1:0], occupied_count[6:2], zero pad
   logic [7:0]       rsp_tdata;

   // Shadow copy of the sphere table.
   logic                         known_valid [SLOTS];
   logic signed [COORD_BITS-1:0] known_x     [SLOTS];
   logic signed [COORD_BITS-1:0] known_y     [SLOTS];
   logic signed [COORD_BITS-1:0] known_z     [SLOTS];
   logic [COORD_BITS-2:0]        known_r     [SLOTS];

   verdict_type pending_verdicts [$];
   int       mismatch_count = 0;
   int       send_idle_pct  = 0;
   int       recv_stall_pct = 0;
   int       hold_left      = 0;
   int unsigned cycle_count = 0;

   // Directed rows: empty table, touching vs. just clear, negative radii,
   // point spheres, coordinate extremes, refused and accepted moves, removes
   // with a negative radius and of an empty slot.
   sphere_row_type directed_rows [NUM_DIRECTED] = '{
      '{sopt_pkg::MODE_REMOVE, 4'd0,  0, 0, 0, 0,
                                 1'b1, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_PLACE,  4'd0,  0, 0, 0, 256,
                                 1'b1, sopt_pkg::STATUS_DONE,       5'd1},
      // exactly touching counts as overlap
      '{sopt_pkg::MODE_PLACE,  4'd1,  512, 0, 0, 256,
                                 1'b1, sopt_pkg::STATUS_OVERLAP,    5'd1},
      '{sopt_pkg::MODE_PLACE,  4'd1,  513, 0, 0, 256,
                                 1'b1, sopt_pkg::STATUS_DONE,       5'd2},
      '{sopt_pkg::MODE_PLACE,  4'd2,  7, 7, 7, -1,
                                 1'b1, sopt_pkg::STATUS_NEG_RADIUS, 5'd2},
      '{sopt_pkg::MODE_PLACE,  4'd2,  0, 0, 0, COORD_MIN,
                                 1'b1, sopt_pkg::STATUS_NEG_RADIUS, 5'd2},
      // point inside sphere 0
      '{sopt_pkg::MODE_PLACE,  4'd3,  0, 0, 0, 0,
                                 1'b1, sopt_pkg::STATUS_OVERLAP,    5'd2},
      '{sopt_pkg::MODE_PLACE,  4'd3,  COORD_MAX, COORD_MAX, COORD_MAX, 0,
                                 1'b1, sopt_pkg::STATUS_DONE,       5'd3},
      // point on point
      '{sopt_pkg::MODE_PLACE,  4'd4,  COORD_MAX, COORD_MAX, COORD_MAX, 0,
                                 1'b1, sopt_pkg::STATUS_OVERLAP,    5'd3},
      '{sopt_pkg::MODE_PLACE,  4'd4,  COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      // move of slot 0 into slot 1's reach: refused, old sphere stays
      '{sopt_pkg::MODE_PLACE,  4'd0,  100, 0, 0, 256,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_PLACE,  4'd0,  -300, 0, 0, 100,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_REMOVE, 4'd1,  COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_REMOVE, 4'd1,  0, 0, 0, 0,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_PLACE,  4'd5,  0, 600, 0, 50,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_PLACE,  4'd6,  0, 0, -700, 400,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_PLACE,  4'd15, COORD_MIN, COORD_MAX, COORD_MIN, 0,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_REMOVE, 4'd15, -1, -1, -1, -1,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      '{sopt_pkg::MODE_PLACE,  4'd15, 0, 0, 0, COORD_MAX,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0},
      // move onto its own position: own slot is not checked
      '{sopt_pkg::MODE_PLACE,  4'd3,  COORD_MAX, COORD_MAX, COORD_MAX, 0,
                                 1'b0, sopt_pkg::STATUS_DONE,       5'd0}
   };

   sphere_overlap_placement_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Predicts the outcome of one request and updates the shadow table.
   // Squared distances need ~42 bits, so 64-bit math is exact.
   function automatic void judge_request(input logic mode,
                                         input logic [SLOT_BITS-1:0] slot,
                                         input logic signed [COORD_BITS-1:0] x,
                                         input logic signed [COORD_BITS-1:0] y,
                                         input logic signed [COORD_BITS-1:0] z,
                                         input logic signed [COORD_BITS-1:0] r,
                                         output sopt_pkg::status_type st,
                                         output logic [COUNT_BITS-1:0] cnt);
      longint dx, dy, dz, dist_sq, reach;
      logic   hit;
      int     filled;
      st  = sopt_pkg::STATUS_DONE;
      hit = 1'b0;
      if (mode == sopt_pkg::MODE_REMOVE) begin
         known_valid[slot] = 1'b0;
      end else if (r < 0) begin
         st = sopt_pkg::STATUS_NEG_RADIUS;
      end else begin
         for (int i = 0; i < SLOTS; i++) begin
            if (i != int'(slot) && known_valid[i]) begin
               dx      = longint'(x) - longint'(known_x[i]);
               dy      = longint'(y) - longint'(known_y[i]);
               dz      = longint'(z) - longint'(known_z[i]);
               dist_sq = dx*dx + dy*dy + dz*dz;
               reach   = longint'(known_r[i]) + longint'(r);
               if (dist_sq <= reach*reach) hit = 1'b1;
            end
         end
         if (hit) begin
            st = sopt_pkg::STATUS_OVERLAP;
         end else begin
            known_x[slot]     = x;
            known_y[slot]     = y;
            known_z[slot]     = z;
            known_r[slot]     = r[COORD_BITS-2:0];
            known_valid[slot] = 1'b1;
         end
      end
      filled = 0;
      for (int i = 0; i < SLOTS; i++) filled += int'(known_valid[i]);
      cnt = filled[COUNT_BITS-1:0];
   endfunction

   // Random request. Most places land in a small cube so they collide often;
   // some are aimed at a stored sphere at exactly touching distance +/- 1 LSB.
   function automatic sphere_row_type random_request();
      sphere_row_type row;
      int pick, anchor, reach, base, coord;
      row      = '0;
      row.slot = SLOT_BITS'($urandom_range(SLOTS - 1));
      pick     = int'($urandom_range(99));
      row.pos_x  = COORD_BITS'($urandom);
      row.pos_y  = COORD_BITS'($urandom);
      row.pos_z  = COORD_BITS'($urandom);
      if (pick < 35) begin
         row.mode   = sopt_pkg::MODE_REMOVE;
         row.radius = COORD_BITS'($urandom);
      end else if (pick < 42) begin
         row.mode   = sopt_pkg::MODE_PLACE;
         row.radius = {1'b1, (COORD_BITS-1)'($urandom)};
      end else if (pick < 55) begin
         // anywhere, radius of any magnitude
         row.mode   = sopt_pkg::MODE_PLACE;
         row.radius = {1'b0, (COORD_BITS-1)'($urandom)} >> $urandom_range(0, COORD_BITS - 2);
      end else begin
         row.mode   = sopt_pkg::MODE_PLACE;
         row.pos_x  = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
         row.pos_y  = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
         row.pos_z  = COORD_BITS'(int'($urandom_range(0, 8191)) - 4096);
         row.radius = COORD_BITS'($urandom_range(0, 1500));
         anchor     = int'($urandom_range(SLOTS - 1));
         if (pick >= 85 && known_valid[anchor]) begin
            row.pos_x = known_x[anchor];
            row.pos_y = known_y[anchor];
            row.pos_z = known_z[anchor];
            reach = int'(known_r[anchor]) + int'(row.radius)
                    + int'($urandom_range(0, 2)) - 1;
            if ($urandom_range(1)) reach = -reach;
            case ($urandom_range(2))
               0: base = int'(known_x[anchor]);
               1: base = int'(known_y[anchor]);
               default: base = int'(known_z[anchor]);
            endcase
            coord = base + reach;
            if (coord > COORD_MAX || coord < COORD_MIN) coord = base - reach;
            // still off the grid: stays concentric
            if (coord > COORD_MAX || coord < COORD_MIN) coord = base;
            case ($urandom_range(2))
               0: row.pos_x = COORD_BITS'(coord);
               1: row.pos_y = COORD_BITS'(coord);
               default: row.pos_z = COORD_BITS'(coord);
            endcase
         end
      end
      return row;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   // Offer one transaction from a falling edge, hold it until accepted,
   // then log its predicted verdict. Returns on the following falling edge.
   task automatic drive_item(input sphere_row_type row);
      verdict_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.mode;
      req_tdata  <= REQ_W'({row.radius, row.pos_z, row.pos_y, row.pos_x, row.slot});
      do @(posedge clock); while (!req_tready);
      judge_request(row.mode, row.slot, row.pos_x, row.pos_y, row.pos_z, row.radius,
                    want.status, want.count);
      if (row.given) begin
         want.status = row.st;
         want.count  = row.cnt;
      end
      pending_verdicts.push_back(want);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (pending_verdicts.size() != 0) @(negedge clock);
   endtask

   // Response side: random back-pressure, plus a long hold-off on request.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Scoreboard: each response against the oldest outstanding verdict.
   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts.size() == 0) begin
            flag_mismatch($sformatf("response with nothing outstanding, data %h", rsp_tdata));
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_tdata[1:0] !== want.status)
               flag_mismatch($sformatf("status got %0d want %0d",
                                       rsp_tdata[1:0], want.status));
            if (rsp_tdata[6:2] !== want.count)
               flag_mismatch($sformatf("occupied_count got %0d want %0d",
                                       rsp_tdata[6:2], want.count));
         end
      end
   end

   // Watchdog.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** sphere_overlap_placement_table: FAILED **");
      $finish;
   end

   // Idle mix per phase: none, sender only, receiver only, both.
   int phase_send_idle [4] = '{0, 46, 0, 24};
   int phase_recv_stall [4] = '{0, 0, 46, 24};

   initial begin
      for (int i = 0; i < SLOTS; i++) known_valid[i] = 1'b0;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, no idling
      for (int i = 0; i < NUM_DIRECTED; i++) drive_item(directed_rows[i]);
      req_tvalid <= 1'b0;
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct  = phase_send_idle[p];
         recv_stall_pct = phase_recv_stall[p];
         // first phase: response side frozen while requests keep coming,
         // so the block backs up and drops req_tready
         if (p == 0) hold_left = HOLDOFF_LEN;
         for (int n = 0; n < PHASE_ITEMS; n++) drive_item(random_request());
         req_tvalid <= 1'b0;
         // sender pauses until every verdict is back
         wait_drained();
      end

      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(negedge clock);
      if (pending_verdicts.size() != 0)
         flag_mismatch($sformatf("%0d responses never arrived", pending_verdicts.size()));

      if (mismatch_count == 0) begin
         $display("** sphere_overlap_placement_table: PASSED **");
      end else begin
         $display("** sphere_overlap_placement_table: FAILED **");
      end
      $finish;
   end

endmodule

/* filelist.f */
hdl/sopt_pkg.sv
hdl/sopt_store.sv
hdl/sopt_mac.sv
hdl/sphere_overlap_placement_table.sv
dv/testbench.sv
